[rtl/fan_rpm_to_duty_map_defines.svh]
// assertion macros used by the checker
`ifndef FAN_RPM_TO_DUTY_MAP_DEFINES_SVH
`define FAN_RPM_TO_DUTY_MAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FRDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FRDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/frdm_pkg.sv]
package frdm_pkg;

  localparam int TGT_W      = 16;
  localparam int RPM_W      = 14;
  localparam int DUTY_W     = 8;
  localparam int SCALE_W    = 8;
  localparam int NUM_W      = RPM_W + SCALE_W;
  localparam int QBITS      = NUM_W - RPM_W;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [SCALE_W-1:0] DUTY_DC_SCALE  = 8'd255;
  localparam logic [SCALE_W-1:0] DUTY_PWM_SCALE = 8'd63;
  localparam logic [DUTY_W-1:0]  DUTY_FULL      = 8'hff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_RPM     = 8'd0,
    REG_MAX_RPM     = 8'd1,
    REG_DC_MODE     = 8'd2,
    REG_FAN_CHANNEL = 8'd3
  } cfg_reg_t;

  // one divider cell's payload: partial remainder, then numerator bits
  // leaving at the top while quotient bits enter at the bottom, then span and flags
  typedef struct packed {
    logic [RPM_W-1:0] rem;
    logic [QBITS-1:0] lowq;
    logic [RPM_W-1:0] span;
    logic             full;
    logic             dc;
    logic             chan;
  } cell_t;

endpackage

[rtl/frdm_ifs.sv]
interface frdm_in_if;
  logic                          valid;
  logic                          ready;
  logic [frdm_pkg::TGT_W-1:0]    target_word;

  modport source (output valid, output target_word, input ready);
  modport sink   (input valid, input target_word, output ready);
endinterface

interface frdm_out_if;
  logic                          valid;
  logic                          ready;
  logic [frdm_pkg::DUTY_W-1:0]   duty;
  logic                          channel;

  modport source (output valid, output duty, output channel, input ready);
  modport sink   (input valid, input duty, input channel, output ready);
endinterface

interface frdm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [frdm_pkg::CFG_ADDR_W-1:0]   addr;
  logic [frdm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/fan_rpm_to_duty_map.sv]
// path from an accepted input beat to its result beat: entry stage with multiply,
//   8 divider cells of one quotient bit each, output register
// throughput: one beat per cycle without back-pressure, set by the 8-cell divider chain
// beats with max_rpm <= min_rpm are accepted and produce no result
// reset (synchronous, rst_n low) clears the valid flags and config registers to 0 and empties the chain
module fan_rpm_to_duty_map (
  input  logic        clk,
  input  logic        rst_n,
  frdm_in_if.sink     in_bus,
  frdm_out_if.source  out_bus,
  frdm_cfg_if.sink    cfg_bus
);

  localparam int CELLS = frdm_pkg::QBITS;

  logic                             link_v   [0:CELLS];
  logic                             link_rdy [0:CELLS];
  frdm_pkg::cell_t                  link_d   [0:CELLS];

  logic                             out_v_r;
  logic [frdm_pkg::DUTY_W-1:0]      duty_r, duty_nxt;
  logic                             chan_r;
  frdm_pkg::cell_t                  last;

  frdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg_bus    (cfg_bus),
    .down_valid (link_v[0]),
    .down_ready (link_rdy[0]),
    .down_data  (link_d[0])
  );

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    frdm_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (link_v[i]),
      .up_ready   (link_rdy[i]),
      .up_data    (link_d[i]),
      .down_valid (link_v[i+1]),
      .down_ready (link_rdy[i+1]),
      .down_data  (link_d[i+1])
    );
  end

  assign last            = link_d[CELLS];
  assign link_rdy[CELLS] = !out_v_r || out_bus.ready;

  // full gives DUTY_FULL, dc takes the quotient; pwm quotient is at most 63, scaled by four
  always_comb begin
    if (last.full) begin
      duty_nxt = frdm_pkg::DUTY_FULL;
    end else if (last.dc) begin
      duty_nxt = last.lowq;
    end else begin
      duty_nxt = {last.lowq[frdm_pkg::DUTY_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (link_rdy[CELLS]) begin
      out_v_r <= link_v[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (link_rdy[CELLS] && link_v[CELLS]) begin
      duty_r <= duty_nxt;
      chan_r <= last.chan;
    end
  end

  assign out_bus.valid   = out_v_r;
  assign out_bus.duty    = duty_r;
  assign out_bus.channel = chan_r;

endmodule

[rtl/frdm_front.sv]
module frdm_front (
  input  logic                clk,
  input  logic                rst_n,
  frdm_in_if.sink             in_bus,
  frdm_cfg_if.sink            cfg_bus,
  output logic                down_valid,
  input  logic                down_ready,
  output frdm_pkg::cell_t     down_data
);

  logic [frdm_pkg::RPM_W-1:0]   min_r, min_nxt;
  logic [frdm_pkg::RPM_W-1:0]   max_r, max_nxt;
  logic                         dc_r, dc_nxt;
  logic                         chan_r, chan_nxt;
  logic                         v_r;
  frdm_pkg::cell_t              d_r, d_nxt;

  logic [frdm_pkg::RPM_W-1:0]   rpm;
  logic [frdm_pkg::RPM_W-1:0]   offs;
  logic [frdm_pkg::SCALE_W-1:0] scale;
  logic [frdm_pkg::NUM_W-1:0]   num;
  logic                         usable;
  logic                         below;
  logic                         above;
  logic                         accept;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    min_nxt  = min_r;
    max_nxt  = max_r;
    dc_nxt   = dc_r;
    chan_nxt = chan_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.addr)
        frdm_pkg::REG_MIN_RPM:     min_nxt  = cfg_bus.data[frdm_pkg::RPM_W-1:0];
        frdm_pkg::REG_MAX_RPM:     max_nxt  = cfg_bus.data[frdm_pkg::RPM_W-1:0];
        frdm_pkg::REG_DC_MODE:     dc_nxt   = cfg_bus.data[0];
        frdm_pkg::REG_FAN_CHANNEL: chan_nxt = cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  assign in_bus.ready = !v_r || down_ready;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    rpm    = in_bus.target_word[frdm_pkg::TGT_W-1:2];
    usable = max_r > min_r;
    below  = rpm < min_r;
    above  = rpm > max_r;
    offs   = rpm - min_r;
    scale  = dc_r ? frdm_pkg::DUTY_DC_SCALE : frdm_pkg::DUTY_PWM_SCALE;
    num    = below ? '0 : frdm_pkg::NUM_W'(offs) * frdm_pkg::NUM_W'(scale);
    d_nxt.rem  = num[frdm_pkg::NUM_W-1:frdm_pkg::QBITS];
    d_nxt.lowq = num[frdm_pkg::QBITS-1:0];
    d_nxt.span = max_r - min_r;
    d_nxt.full = above;
    d_nxt.dc   = dc_r;
    d_nxt.chan = chan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      max_r  <= '0;
      dc_r   <= 1'b0;
      chan_r <= 1'b0;
      v_r    <= 1'b0;
    end else begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      dc_r   <= dc_nxt;
      chan_r <= chan_nxt;
      // unusable calibration swallows the beat
      if (in_bus.ready) v_r <= accept && usable;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) d_r <= d_nxt;
  end

  assign down_valid = v_r;
  assign down_data  = d_r;

endmodule

[rtl/frdm_div_cell.sv]
module frdm_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  frdm_pkg::cell_t  up_data,
  output logic             down_valid,
  input  logic             down_ready,
  output frdm_pkg::cell_t  down_data
);

  logic                          v_r;
  frdm_pkg::cell_t               d_r, d_nxt;
  logic [frdm_pkg::RPM_W:0]      part;
  logic [frdm_pkg::RPM_W:0]      diff;
  logic                          ge;

  // one restoring step: bring down the next numerator bit, try the span
  always_comb begin
    part  = {up_data.rem, up_data.lowq[frdm_pkg::QBITS-1]};
    diff  = part - {1'b0, up_data.span};
    ge    = part >= {1'b0, up_data.span};
    d_nxt = up_data;
    d_nxt.rem  = ge ? diff[frdm_pkg::RPM_W-1:0] : part[frdm_pkg::RPM_W-1:0];
    d_nxt.lowq = {up_data.lowq[frdm_pkg::QBITS-2:0], ge};
  end

  assign up_ready = !v_r || down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

  assign down_valid = v_r;
  assign down_data  = d_r;

endmodule

[rtl/frdm_chk.sv]
`include "fan_rpm_to_duty_map_defines.svh"

module frdm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [frdm_pkg::DUTY_W-1:0]       duty,
  input logic                              channel,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [frdm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input logic [frdm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic dc_r;
  logic chan_r;

  // shadow of the mode and channel registers as seen on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r   <= 1'b0;
      chan_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_addr == frdm_pkg::REG_DC_MODE)     dc_r   <= cfg_data[0];
      if (cfg_addr == frdm_pkg::REG_FAN_CHANNEL) chan_r <= cfg_data[0];
    end
  end

  `FRDM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid,
    "result beat dropped while stalled")
  `FRDM_ASSERT_NXT(a_duty_stable, out_valid && !out_ready,
    $stable(duty) && $stable(channel), "result payload changed while stalled")
  `FRDM_ASSERT_NOW(a_pwm_step, out_valid && !dc_r,
    duty[1:0] == 2'b00 || duty == frdm_pkg::DUTY_FULL, "pwm duty not a multiple of four")
  `FRDM_ASSERT_NOW(a_channel, out_valid, channel == chan_r,
    "result channel differs from fan_channel")

endmodule

bind fan_rpm_to_duty_map frdm_chk u_frdm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .duty      (out_bus.duty),
  .channel   (out_bus.channel),
  .cfg_valid (cfg_bus.valid),
  .cfg_ready (cfg_bus.ready),
  .cfg_addr  (cfg_bus.addr),
  .cfg_data  (cfg_bus.data)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import frdm_pkg::*;

  localparam int PIPE_LATENCY   = 10;
  localparam int DRAIN_CYCLES   = 3 * PIPE_LATENCY;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;
  localparam int RPM_TOP        = (1 << RPM_W) - 1;
  localparam int PHASE_ITEMS    = 115;

  // no register lives at this index
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_REG = 8'd200;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              channel;
  } duty_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  frdm_in_if  in_if();
  frdm_out_if out_if();
  frdm_cfg_if cfg_if();

  fan_rpm_to_duty_map u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // calibration as the block should hold it
  logic [RPM_W-1:0] cal_min  = '0;
  logic [RPM_W-1:0] cal_max  = '0;
  logic             dc_sel   = 1'b0;
  logic             chan_sel = 1'b0;

  duty_beat_t pending_duty[$];

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int targets_sent   = 0;
  int duties_checked = 0;
  int reg_writes     = 0;
  int mismatches     = 0;

  function automatic logic predict_duty(input logic [TGT_W-1:0] tw, output duty_beat_t res);
    logic [RPM_W-1:0] rpm;
    int unsigned span;
    int unsigned offs;
    rpm = tw[TGT_W-1:2];
    res.channel = chan_sel;
    res.duty = '0;
    if (cal_max <= cal_min) return 1'b0;
    if (rpm < cal_min) begin
      res.duty = '0;
    end else if (rpm > cal_max) begin
      res.duty = DUTY_FULL;
    end else begin
      span = int'(cal_max) - int'(cal_min);
      offs = int'(rpm) - int'(cal_min);
      if (dc_sel) res.duty = DUTY_W'((offs * DUTY_DC_SCALE) / span);
      else res.duty = DUTY_W'(((offs * DUTY_PWM_SCALE) / span) << 2);
    end
    return 1'b1;
  endfunction

  // receiver: random stalls, or a counted hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // tracks config, predicts on every accepted target, checks every result beat
  always @(posedge clk) begin
    duty_beat_t want;
    duty_beat_t got;
    logic       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        reg_writes++;
        case (cfg_if.addr)
          REG_MIN_RPM:     cal_min  = cfg_if.data[RPM_W-1:0];
          REG_MAX_RPM:     cal_max  = cfg_if.data[RPM_W-1:0];
          REG_DC_MODE:     dc_sel   = cfg_if.data[0];
          REG_FAN_CHANNEL: chan_sel = cfg_if.data[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        targets_sent++;
        if (predict_duty(in_if.target_word, want)) pending_duty.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got.duty = out_if.duty;
        got.channel = out_if.channel;
        if (pending_duty.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: duty=%0d channel=%0d", got.duty, got.channel);
        end else begin
          want = pending_duty.pop_front();
          duties_checked++;
          if (got.duty !== want.duty || got.channel !== want.channel) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: duty exp %0d got %0d, channel exp %0d got %0d",
                       want.duty, got.duty, want.channel, got.channel);
          end
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_duty.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // leaves valid high at the accepting edge; a gap in the next call or wait_idle lowers it
  task automatic send_target(input logic [TGT_W-1:0] tw);
    while ($urandom_range(99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.target_word <= tw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic cfg_done();
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are junk on purpose, the block must drop them
  task automatic configure(input int lo, input int hi, input logic dc, input logic ch);
    write_reg(REG_MIN_RPM, {2'($urandom_range(3)), RPM_W'(lo)});
    write_reg(REG_MAX_RPM, {2'($urandom_range(3)), RPM_W'(hi)});
    write_reg(REG_DC_MODE, {15'($urandom), dc});
    write_reg(REG_FAN_CHANNEL, {15'($urandom), ch});
    cfg_done();
  endtask

  // no-result beats are dropped at the entry stage and never reach the divider chain
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_duty.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TGT_W-1:0] pick_target(input int lo, input int hi);
    int wlo;
    int whi;
    if (hi > lo && $urandom_range(9) < 7) begin
      wlo = (lo > 2) ? lo - 2 : 0;
      whi = (hi + 2 > RPM_TOP) ? RPM_TOP : hi + 2;
      return {RPM_W'($urandom_range(whi, wlo)), 2'($urandom_range(3))};
    end
    return TGT_W'($urandom);
  endfunction

  // both bounds at 0 after reset: nothing may come out
  task automatic test_after_reset();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    send_target(16'h0000);
    send_target(16'hffff);
    send_target(16'h1234);
    wait_idle();
  endtask

  task automatic test_directed();
    configure(1000, 5000, 1'b1, 1'b1);
    send_target(16'h0000);
    send_target({14'd999, 2'd3});
    send_target({14'd1000, 2'd0});
    send_target({14'd1001, 2'd1});
    send_target({14'd3000, 2'd2});
    send_target({14'd4999, 2'd3});
    send_target({14'd5000, 2'd3});
    send_target({14'd5001, 2'd0});
    send_target(16'hffff);
    wait_idle();
    configure(1000, 5000, 1'b0, 1'b0);
    send_target({14'd1000, 2'd0});
    send_target({14'd3000, 2'd1});
    send_target({14'd5000, 2'd0});
    send_target({14'd5001, 2'd2});
    wait_idle();
    // one-rpm span at the top of the range
    configure(RPM_TOP - 1, RPM_TOP, 1'b1, 1'b1);
    send_target({14'd16382, 2'd0});
    send_target(16'hffff);
    send_target(16'h0000);
    wait_idle();
    // wide data is cut to the field, an unmapped index changes nothing
    write_reg(REG_MAX_RPM, 16'hc7d0);
    write_reg(REG_MIN_RPM, 16'h41f4);
    write_reg(REG_DC_MODE, 16'hfffe);
    write_reg(REG_FAN_CHANNEL, 16'h0003);
    write_reg(UNMAPPED_REG, 16'h0000);
    cfg_done();
    send_target({14'd1250, 2'd0});
    send_target({14'd2000, 2'd3});
    wait_idle();
    configure(700, 700, 1'b1, 1'b0);
    send_target({14'd700, 2'd0});
    wait_idle();
    configure(900, 100, 1'b0, 1'b1);
    send_target({14'd500, 2'd0});
    wait_idle();
  endtask

  task automatic test_random_phase(input int gap_pct, input int stall_pct);
    int lo;
    int hi;
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (4) begin
      case ($urandom_range(9))
        0: begin
          lo = $urandom_range(RPM_TOP);
          hi = $urandom_range(lo);
        end
        1: begin
          lo = $urandom_range(RPM_TOP - 1);
          hi = lo + $urandom_range(4, 1);
          if (hi > RPM_TOP) hi = RPM_TOP;
        end
        2: begin
          lo = 0;
          hi = RPM_TOP;
        end
        default: begin
          lo = $urandom_range(RPM_TOP - 1);
          hi = $urandom_range(RPM_TOP, lo + 1);
        end
      endcase
      configure(lo, hi, 1'($urandom), 1'($urandom));
      repeat (PHASE_ITEMS) send_target(pick_target(lo, hi));
      wait_idle();
    end
  endtask

  // receiver holds off long enough for the chain to fill and stall the input
  task automatic test_backpressure();
    src_gap_pct = 0;
    sink_stall_pct = 0;
    configure(200, 12000, 1'b1, 1'b1);
    hold_left = HOLD_CYCLES;
    repeat (80) send_target(pick_target(200, 12000));
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.target_word = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_directed();
    test_random_phase(0, 0);
    test_random_phase(60, 0);
    test_random_phase(0, 60);
    test_random_phase(19, 19);
    test_backpressure();

    if (pending_duty.size() != 0) begin
      mismatches += pending_duty.size();
      $display("%0d duty results never arrived", pending_duty.size());
    end
    $display("run: %0d targets, %0d duty results checked, %0d register writes",
             targets_sent, duties_checked, reg_writes);
    $display("     DC and PWM scaling, clamps, unusable calibration, stalls and backpressure");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[fan_rpm_to_duty_map.f]
+incdir+rtl
rtl/frdm_pkg.sv
rtl/frdm_ifs.sv
rtl/frdm_front.sv
rtl/frdm_div_cell.sv
rtl/fan_rpm_to_duty_map.sv
rtl/frdm_chk.sv
tb/sv/tb.sv
